// ===== rtl/rccl_pkg.sv =====
package rccl_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int BIN_BITS    = 44;

  localparam int N_W      = $clog2(MAX_WINDOW) + 1;
  localparam int HA_DEPTH = 2 * MAX_WINDOW;
  localparam int HB_DEPTH = 3 * MAX_WINDOW;
  localparam int HA_AW    = $clog2(HA_DEPTH);
  localparam int HB_AW    = $clog2(HB_DEPTH);
  localparam int BIN_AW   = HA_AW;
  localparam int CLR_LAST = HB_DEPTH - 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW   = 2'd0,
    CFG_SMOOTH   = 2'd1,
    CFG_SELECTED = 2'd2,
    CFG_BYPASS   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_BEST  = 2'd0,
    DIV_WORST = 2'd1,
    DIV_SEL   = 2'd2
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_LAT,
    ST_BIN_RD,
    ST_BIN_M1,
    ST_BIN_M2,
    ST_BIN_ACC,
    ST_BIN_DIF,
    ST_BIN_ML,
    ST_BIN_MH,
    ST_BIN_UPD,
    ST_HIST_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DIV_SETUP,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic               end_of_block;
  } in_t;

  typedef struct packed {
    logic signed [11:0] best_lag;
    logic signed [15:0] best_corr;
    logic signed [11:0] worst_lag;
    logic signed [15:0] worst_corr;
    logic signed [11:0] selected_lag;
    logic signed [15:0] selected_value;
  } out_t;

endpackage

// ===== rtl/running_cross_correlation_lag_unit.sv =====
// Running cross-correlation lag unit. Each input transfer carries one sample
// pair; the unit keeps 2N sliding-window correlation bins for lags N down to
// 1-N plus exponentially smoothed copies, and on an end-of-block transfer it
// returns one result transfer with the lags and Q1.15 normalized values of the
// largest, the smallest and the selected smoothed bin. All work runs on one
// shared 24x17 multiplier under a sequencer, so the unit takes one item at a
// time: a sample runs one pass over all 2N bins (eight steps per bin: two
// products for the window update, two partial products for the smoothing),
// and an end-of-block sample adds a scan of the bins plus three 16-step
// normalizing divisions. After reset, after any write of the window length
// and after bypass is switched on, the unit zeroes its delay lines and bin
// memories in a pass over all 3*MAX_WINDOW addresses (3072), during which
// it takes no input. In bypass an end-of-block sample yields an all-zero
// result and other samples are dropped.
module running_cross_correlation_lag_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rccl_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rccl_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [rccl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rccl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rccl_pkg::*;

  // Sample and bin memories; all reads are registered.
  logic signed [15:0]         ha_mem [HA_DEPTH];
  logic signed [15:0]         hb_mem [HB_DEPTH];
  logic signed [BIN_BITS-1:0] wb_mem [HA_DEPTH];
  logic signed [BIN_BITS-1:0] sb_mem [HA_DEPTH];

  logic                       ha_we, hb_we, wb_we, sb_we;
  logic [HA_AW-1:0]           ha_wa, ha_ra0, ha_ra1;
  logic [HB_AW-1:0]           hb_wa;
  logic [BIN_AW-1:0]          bin_wa;
  logic signed [15:0]         ha_wd, hb_wd, ha_rd0, ha_rd1, hb_rd0, hb_rd1;
  logic signed [BIN_BITS-1:0] wb_wd, sb_wd, wb_rd, sb_rd;

  // Configuration registers.
  logic [10:0] window_length_r;
  logic [15:0] smoothing_factor_r;
  logic [10:0] selected_index_r;
  logic        bypass_r;

  state_t state_r, state_nxt;

  logic [HB_AW-1:0]  clr_cnt_r;
  logic [HA_AW-1:0]  a_pos_r;
  logic [HB_AW-1:0]  wp_r;
  logic [HB_AW-1:0]  p_out_r, p_in_r;
  logic [BIN_AW-1:0] bin_i_r;
  in_t               in_r;

  logic signed [15:0]         a_in_r, a_out_r;
  logic signed [40:0]         prod_r;
  logic [38:0]                lo_r;
  logic signed [BIN_BITS-1:0] w_r;
  logic signed [BIN_BITS:0]   d_r;

  logic signed [BIN_BITS-1:0] best_v_r, worst_v_r, sel_v_r;
  logic [BIN_AW-1:0]          best_idx_r, worst_idx_r;
  logic [BIN_BITS-1:0]        m_r;

  div_sel_t           div_sel_r;
  logic [46:0]        rem_r;
  logic [15:0]        num_lo_r;
  logic [15:0]        q_r;
  logic [3:0]         div_cnt_r;
  logic               neg_r;
  logic signed [15:0] best_val_r, worst_val_r, sel_val_r;

  logic out_valid_r;
  out_t out_r;

  // Effective window and derived sizes.
  logic [10:0]       n_raw;
  logic [N_W-1:0]    n_eff;
  logic [HA_AW:0]    nf;
  logic [HB_AW:0]    nb;
  logic [BIN_AW-1:0] nf_m1, sel_clip;

  always_comb begin
    n_raw = {window_length_r[10:2], 2'b00};
    if (n_raw < 11'd4) begin
      n_eff = N_W'(4);
    end else if (n_raw > 11'(MAX_WINDOW)) begin
      n_eff = N_W'(MAX_WINDOW);
    end else begin
      n_eff = N_W'(n_raw);
    end
    nf       = (HA_AW+1)'(n_eff) << 1;
    nb       = (HB_AW+1)'(nf) + (HB_AW+1)'(n_eff);
    nf_m1    = BIN_AW'(nf - 1'b1);
    sel_clip = (BIN_AW'(selected_index_r) > nf_m1) ? nf_m1 : BIN_AW'(selected_index_r);
  end

  // A clear is requested by any window write or by turning bypass on.
  logic clr_req;
  assign clr_req = cfg_we && ((cfg_index == CFG_WINDOW) ||
                   (cfg_index == CFG_BYPASS && cfg_data[0] && !bypass_r));

  // Delay line pointer arithmetic.
  logic [HA_AW:0] a_in_sum;
  logic [HB_AW:0] p_in_start, p_out_inc, p_in_inc, wp_inc;
  logic [HA_AW:0] a_pos_inc;

  always_comb begin
    a_in_sum   = (HA_AW+1)'(a_pos_r) + (HA_AW+1)'(n_eff);
    ha_ra1     = (a_in_sum >= nf) ? HA_AW'(a_in_sum - nf) : HA_AW'(a_in_sum);
    ha_ra0     = a_pos_r;
    p_in_start = (HB_AW+1)'(wp_r) + (HB_AW+1)'(n_eff);
    if (p_in_start >= nb) begin
      p_in_start = p_in_start - nb;
    end
    p_out_inc = (HB_AW+1)'(p_out_r) + 1'b1;
    p_in_inc  = (HB_AW+1)'(p_in_r) + 1'b1;
    wp_inc    = (HB_AW+1)'(wp_r) + 1'b1;
    a_pos_inc = (HA_AW+1)'(a_pos_r) + 1'b1;
  end

  // Shared multiplier.
  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [40:0] mul_p;
  logic signed [16:0] tau;

  assign tau   = {1'b0, smoothing_factor_r};
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = {{8{a_in_r[15]}}, a_in_r};
    mul_b = {hb_rd1[15], hb_rd1};
    case (state_r)
      ST_BIN_M2: begin
        mul_a = {{8{a_out_r[15]}}, a_out_r};
        mul_b = {hb_rd0[15], hb_rd0};
      end
      ST_BIN_ML: begin
        mul_a = {1'b0, d_r[22:0]};
        mul_b = tau;
      end
      ST_BIN_MH: begin
        mul_a = {{2{d_r[BIN_BITS]}}, d_r[BIN_BITS:23]};
        mul_b = tau;
      end
      default: begin
      end
    endcase
  end

  // Smoothing update: s += floor((d * tau + 2^15) / 2^16).
  logic signed [63:0]         smooth_sum;
  logic signed [63:0]         smooth_step;
  logic signed [BIN_BITS-1:0] s_new;

  always_comb begin
    smooth_sum  = (64'(prod_r) <<< 23) + $signed({25'd0, lo_r}) + 64'sd32768;
    smooth_step = smooth_sum >>> 16;
    s_new       = sb_rd + smooth_step[BIN_BITS-1:0];
  end

  // Bin scan and divider helpers.
  logic [BIN_BITS-1:0]        scan_mag;
  logic signed [BIN_BITS-1:0] div_s;
  logic [BIN_BITS-1:0]        div_mag;
  logic [60:0]                div_num;
  logic [46:0]                div_t, div_d;
  logic                       div_ge;
  logic signed [15:0]         div_val;

  always_comb begin
    scan_mag = sb_rd[BIN_BITS-1] ? BIN_BITS'(-sb_rd) : BIN_BITS'(sb_rd);
    case (div_sel_r)
      DIV_BEST:  div_s = best_v_r;
      DIV_WORST: div_s = worst_v_r;
      default:   div_s = sel_v_r;
    endcase
    div_mag = div_s[BIN_BITS-1] ? BIN_BITS'(-div_s) : BIN_BITS'(div_s);
    div_num = {1'b0, div_mag, 16'd0} + 61'(m_r);
    div_t   = {rem_r[45:0], num_lo_r[15]};
    div_d   = 47'({m_r, 1'b0});
    div_ge  = div_t >= div_d;
    if (m_r == '0) begin
      div_val = '0;
    end else if (neg_r) begin
      div_val = -$signed(q_r);
    end else if (q_r > 16'd32767) begin
      div_val = 16'sd32767;
    end else begin
      div_val = $signed(q_r);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (clr_cnt_r == HB_AW'(CLR_LAST)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (bypass_r) begin
            state_nxt = in_data.end_of_block ? ST_EMIT : ST_IDLE;
          end else begin
            state_nxt = ST_A_RD;
          end
        end
      end
      ST_A_RD:      state_nxt = ST_A_LAT;
      ST_A_LAT:     state_nxt = ST_BIN_RD;
      ST_BIN_RD:    state_nxt = ST_BIN_M1;
      ST_BIN_M1:    state_nxt = ST_BIN_M2;
      ST_BIN_M2:    state_nxt = ST_BIN_ACC;
      ST_BIN_ACC:   state_nxt = ST_BIN_DIF;
      ST_BIN_DIF:   state_nxt = ST_BIN_ML;
      ST_BIN_ML:    state_nxt = ST_BIN_MH;
      ST_BIN_MH:    state_nxt = ST_BIN_UPD;
      ST_BIN_UPD:   state_nxt = (bin_i_r == nf_m1) ? ST_HIST_WR : ST_BIN_RD;
      ST_HIST_WR:   state_nxt = in_r.end_of_block ? ST_SCAN_RD : ST_IDLE;
      ST_SCAN_RD:   state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP:  state_nxt = (bin_i_r == nf_m1) ? ST_DIV_SETUP : ST_SCAN_RD;
      ST_DIV_SETUP: state_nxt = ST_DIV_RUN;
      ST_DIV_RUN:   if (div_cnt_r == 4'd0) state_nxt = ST_DIV_END;
      ST_DIV_END:   state_nxt = (div_sel_r == DIV_SEL) ? ST_EMIT : ST_DIV_SETUP;
      ST_EMIT:      if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
    if (clr_req) begin
      state_nxt = ST_CLEAR;
    end
  end

  // Memory ports and handshake outputs.
  always_comb begin
    ha_we  = 1'b0;
    hb_we  = 1'b0;
    wb_we  = 1'b0;
    sb_we  = 1'b0;
    ha_wa  = a_pos_r;
    hb_wa  = wp_r;
    bin_wa = bin_i_r;
    ha_wd  = in_r.sample_a;
    hb_wd  = in_r.sample_b;
    wb_wd  = w_r;
    sb_wd  = s_new;
    case (state_r)
      ST_CLEAR: begin
        ha_we  = clr_cnt_r < HB_AW'(HA_DEPTH);
        hb_we  = 1'b1;
        wb_we  = clr_cnt_r < HB_AW'(HA_DEPTH);
        sb_we  = clr_cnt_r < HB_AW'(HA_DEPTH);
        ha_wa  = clr_cnt_r[HA_AW-1:0];
        hb_wa  = clr_cnt_r;
        bin_wa = clr_cnt_r[BIN_AW-1:0];
        ha_wd  = '0;
        hb_wd  = '0;
        wb_wd  = '0;
        sb_wd  = '0;
      end
      ST_HIST_WR: begin
        ha_we = 1'b1;
        hb_we = 1'b1;
      end
      ST_BIN_DIF: wb_we = 1'b1;
      ST_BIN_UPD: sb_we = 1'b1;
      default: begin
      end
    endcase
    in_ready  = (state_r == ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (ha_we) ha_mem[ha_wa] <= ha_wd;
    ha_rd0 <= ha_mem[ha_ra0];
    ha_rd1 <= ha_mem[ha_ra1];
  end

  always_ff @(posedge clk) begin
    if (hb_we) hb_mem[hb_wa] <= hb_wd;
    hb_rd0 <= hb_mem[p_out_r];
    hb_rd1 <= hb_mem[p_in_r];
  end

  always_ff @(posedge clk) begin
    if (wb_we) wb_mem[bin_wa] <= wb_wd;
    wb_rd <= wb_mem[bin_i_r];
  end

  always_ff @(posedge clk) begin
    if (sb_we) sb_mem[bin_wa] <= sb_wd;
    sb_rd <= sb_mem[bin_i_r];
  end

  // Sequencer registers and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_CLEAR;
      window_length_r    <= 11'd256;
      smoothing_factor_r <= 16'd64;
      selected_index_r   <= 11'd1024;
      bypass_r           <= 1'b0;
      clr_cnt_r          <= '0;
      a_pos_r            <= '0;
      wp_r               <= '0;
      out_valid_r        <= 1'b0;
      bin_i_r            <= '0;
      div_sel_r          <= DIV_BEST;
      div_cnt_r          <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW:   window_length_r    <= cfg_data[10:0];
          CFG_SMOOTH:   smoothing_factor_r <= cfg_data[15:0];
          CFG_SELECTED: selected_index_r   <= cfg_data[10:0];
          CFG_BYPASS:   bypass_r           <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // In the emit state the output register is reloaded below instead.
      if (out_valid_r && out_ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end

      // A clear restarts the sweep and rewinds both delay line pointers.
      if (clr_req) begin
        clr_cnt_r <= '0;
        a_pos_r   <= '0;
        wp_r      <= '0;
      end else begin
        case (state_r)
          ST_CLEAR: clr_cnt_r <= clr_cnt_r + 1'b1;
          ST_IDLE: begin
            in_r <= in_data;
          end
          ST_A_RD: begin
            bin_i_r <= '0;
            p_out_r <= wp_r;
            p_in_r  <= HB_AW'(p_in_start);
          end
          ST_A_LAT: begin
            a_out_r <= ha_rd0;
            a_in_r  <= ha_rd1;
          end
          ST_BIN_M1: prod_r <= mul_p;
          ST_BIN_M2: begin
            w_r    <= wb_rd + BIN_BITS'(prod_r);
            prod_r <= mul_p;
          end
          ST_BIN_ACC: w_r <= w_r - BIN_BITS'(prod_r);
          ST_BIN_DIF: d_r <= {w_r[BIN_BITS-1], w_r} - {sb_rd[BIN_BITS-1], sb_rd};
          ST_BIN_ML:  prod_r <= mul_p;
          ST_BIN_MH: begin
            lo_r   <= prod_r[38:0];
            prod_r <= mul_p;
          end
          ST_BIN_UPD: begin
            bin_i_r <= bin_i_r + 1'b1;
            p_out_r <= (p_out_inc == nb) ? '0 : HB_AW'(p_out_inc);
            p_in_r  <= (p_in_inc == nb) ? '0 : HB_AW'(p_in_inc);
          end
          ST_HIST_WR: begin
            a_pos_r   <= (a_pos_inc == nf) ? '0 : HA_AW'(a_pos_inc);
            wp_r      <= (wp_inc == nb) ? '0 : HB_AW'(wp_inc);
            bin_i_r   <= '0;
            div_sel_r <= DIV_BEST;
          end
          ST_SCAN_CMP: begin
            if (bin_i_r == '0) begin
              best_v_r    <= sb_rd;
              worst_v_r   <= sb_rd;
              best_idx_r  <= '0;
              worst_idx_r <= '0;
              m_r         <= scan_mag;
            end else begin
              if (sb_rd > best_v_r) begin
                best_v_r   <= sb_rd;
                best_idx_r <= bin_i_r;
              end
              if (sb_rd < worst_v_r) begin
                worst_v_r   <= sb_rd;
                worst_idx_r <= bin_i_r;
              end
              if (scan_mag > m_r) begin
                m_r <= scan_mag;
              end
            end
            if (bin_i_r == sel_clip) begin
              sel_v_r <= sb_rd;
            end
            bin_i_r <= bin_i_r + 1'b1;
          end
          ST_DIV_SETUP: begin
            rem_r     <= 47'(div_num[60:16]);
            num_lo_r  <= div_num[15:0];
            q_r       <= '0;
            neg_r     <= div_s[BIN_BITS-1];
            div_cnt_r <= 4'd15;
          end
          ST_DIV_RUN: begin
            rem_r     <= div_ge ? (div_t - div_d) : div_t;
            q_r       <= {q_r[14:0], div_ge};
            num_lo_r  <= {num_lo_r[14:0], 1'b0};
            div_cnt_r <= div_cnt_r - 1'b1;
          end
          ST_DIV_END: begin
            case (div_sel_r)
              DIV_BEST:  best_val_r  <= div_val;
              DIV_WORST: worst_val_r <= div_val;
              default:   sel_val_r   <= div_val;
            endcase
            div_sel_r <= (div_sel_r == DIV_BEST) ? DIV_WORST : DIV_SEL;
          end
          ST_EMIT: begin
            if (!out_valid_r || out_ready) begin
              out_valid_r <= 1'b1;
              if (bypass_r) begin
                out_r <= '0;
              end else begin
                out_r.best_lag       <= {1'b0, n_eff} - {1'b0, best_idx_r};
                out_r.best_corr      <= best_val_r;
                out_r.worst_lag      <= {1'b0, n_eff} - {1'b0, worst_idx_r};
                out_r.worst_corr     <= worst_val_r;
                out_r.selected_lag   <= {1'b0, n_eff} - {1'b0, sel_clip};
                out_r.selected_value <= sel_val_r;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // A window write always starts a clearing sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_WINDOW) |=> (state_r == ST_CLEAR && clr_cnt_r == '0))
    else $error("window write did not start a clearing sweep");

  // No input transfer is taken while the memories are being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("input taken during clearing sweep");

  // The B delay line pointers stay inside the active 3N window during a bin pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIN_RD) |-> ((HB_AW+1)'(p_out_r) < nb && (HB_AW+1)'(p_in_r) < nb))
    else $error("delay line pointer out of range");

endmodule
